// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file sos_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active (reset is active low).
`define SOS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SOS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sos_pkg.sv -----
// Shared types and constants of the shell operator spacer.
// No dependencies; imported by every module of the block.
package sos_pkg;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int JOB_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       line_done;
    } t_out_beat;

    // One unit of work for the back end: expand one character, or a bare end marker.
    typedef struct packed {
        logic       bare;
        logic [7:0] ch;
        logic [7:0] prev;
        logic [7:0] nxt;
        logic       first;
        logic       done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- sv/shell_operator_spacer.sv -----
// Top level of the shell operator spacer: front end, job queue and back end.
// Depends on sos_pkg, sos_front, sos_job_fifo and sos_back.

// Normalizes a command line fed in one byte per beat, the last byte flagged by line_end.
// Spaces go around ';' separators and around '&&' and '||' pairs, judged from the
// original bytes before and after each character; a '#' at the start of a line or
// after a space, or a NUL byte, drops the rest of the line. Every line ends with one
// result carrying line_done, a bare marker (byte_valid low, out_byte zero) if the
// closing beat has no byte to give. One byte is held back to see its successor, so a
// byte's output leaves only when the next byte arrives or the line ends. Both sides
// are queues: push while full is low, pop while empty is low. The back end writes
// one result beat per cycle while pop keeps taking them, so an input beat gives
// zero to three result beats (up to six for the closing beat of a line). The front
// end takes a beat per cycle while full is low, and raises full after a closing beat
// that releases two characters, to push the second job. A queue of QUEUE_DEPTH jobs
// lets the front keep accepting while the back is busy or stalled by pop.
module shell_operator_spacer #(
    parameter int QUEUE_DEPTH = sos_pkg::JOB_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sos_pkg::t_in_beat  i_in_beat,
    output logic               empty,
    input  logic               pop,
    output sos_pkg::t_out_beat o_out_beat
);
    import sos_pkg::*;

    t_queue_status q_status;
    t_job          push_job;
    t_job          head_job;
    logic          job_push;
    logic          job_pop;

    // accept beats, classify cuts and line ends, issue expansion jobs
    sos_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in_beat  (i_in_beat),
        .i_q_status (q_status),
        .o_job_push (job_push),
        .o_job      (push_job)
    );

    // decouple the two sides
    sos_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_push),
        .i_job    (push_job),
        .i_pop    (job_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // expand the oldest job into result beats
    sos_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_status.empty),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ----- sv/sos_front.sv -----
// Front end: accepts input beats, tracks line context and issues expansion jobs.
// Depends on sos_pkg.
module sos_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  sos_pkg::t_in_beat    i_in_beat,
    input  sos_pkg::t_queue_status i_q_status,
    output logic                 o_job_push,
    output sos_pkg::t_job        o_job
);
    import sos_pkg::*;

    logic [7:0] r_held_char, n_held_char;
    logic [7:0] r_before_held, n_before_held;
    logic       r_held_valid, n_held_valid;
    logic       r_held_is_first, n_held_is_first;
    logic       r_comment_cut, n_comment_cut;
    logic       r_pend, n_pend;
    t_job       r_pend_job, n_pend_job;

    logic       accept;
    logic       cut;
    logic       last;
    logic [7:0] c;
    logic       job1_v, job2_v;
    t_job       job1, job2;

    assign o_full = r_pend || i_q_status.full;
    assign accept = i_push && !o_full;
    assign c      = i_in_beat.in_byte;
    assign last   = i_in_beat.line_end;
    assign cut    = (c == CH_NUL) ||
                    (c == CH_HASH && (!r_held_valid || r_held_char == CH_SPACE));

    always_comb begin
        // held character, expanded with the new byte (or NUL on a cut) as context
        job1_v     = accept && !r_comment_cut && r_held_valid;
        job1.bare  = 1'b0;
        job1.ch    = r_held_char;
        job1.prev  = r_before_held;
        job1.nxt   = cut ? CH_NUL : c;
        job1.first = r_held_is_first;
        job1.done  = cut && last;

        // closing work of the line: bare marker or final character
        job2_v     = 1'b0;
        job2.bare  = 1'b1;
        job2.ch    = CH_NUL;
        job2.prev  = CH_NUL;
        job2.nxt   = CH_NUL;
        job2.first = 1'b0;
        job2.done  = 1'b1;
        if (accept && last) begin
            if (r_comment_cut) begin
                job2_v = 1'b1;
            end else if (cut) begin
                job2_v = !r_held_valid;
            end else begin
                job2_v     = 1'b1;
                job2.bare  = 1'b0;
                job2.ch    = c;
                job2.prev  = r_held_valid ? r_held_char : CH_NUL;
                job2.first = !r_held_valid;
            end
        end

        o_job_push = r_pend || job1_v || job2_v;
        if (r_pend) begin
            o_job = r_pend_job;
        end else if (job1_v) begin
            o_job = job1;
        end else begin
            o_job = job2;
        end

        // hold the second job of a step for the next free cycle
        n_pend     = r_pend ? i_q_status.full : (job1_v && job2_v);
        n_pend_job = (job1_v && job2_v) ? job2 : r_pend_job;

        n_held_char     = r_held_char;
        n_before_held   = r_before_held;
        n_held_valid    = r_held_valid;
        n_held_is_first = r_held_is_first;
        n_comment_cut   = r_comment_cut;
        if (accept) begin
            if (last) begin
                n_held_char     = CH_NUL;
                n_before_held   = CH_NUL;
                n_held_valid    = 1'b0;
                n_held_is_first = 1'b1;
                n_comment_cut   = 1'b0;
            end else if (r_comment_cut) begin
                n_comment_cut = 1'b1;
            end else if (cut) begin
                n_comment_cut = 1'b1;
                n_held_valid  = 1'b0;
            end else begin
                n_before_held   = r_held_valid ? r_held_char : CH_NUL;
                n_held_is_first = !r_held_valid;
                n_held_char     = c;
                n_held_valid    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char     <= CH_NUL;
            r_before_held   <= CH_NUL;
            r_held_valid    <= 1'b0;
            r_held_is_first <= 1'b1;
            r_comment_cut   <= 1'b0;
            r_pend          <= 1'b0;
        end else begin
            r_held_char     <= n_held_char;
            r_before_held   <= n_before_held;
            r_held_valid    <= n_held_valid;
            r_held_is_first <= n_held_is_first;
            r_comment_cut   <= n_comment_cut;
            r_pend          <= n_pend;
        end
        r_pend_job <= n_pend_job;
    end

endmodule

// ----- sv/sos_job_fifo.sv -----
// Short job queue between the front and back ends.
// Depends on sos_pkg.
module sos_job_fifo #(
    parameter int DEPTH = sos_pkg::JOB_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  sos_pkg::t_job          i_job,
    input  logic                   i_pop,
    output sos_pkg::t_job          o_job,
    output sos_pkg::t_queue_status o_status
);
    import sos_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- sv/sos_back.sv -----
// Back end: expands each job into one to three output beats, one per cycle while pop takes them.
// Depends on sos_pkg.
module sos_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  sos_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output sos_pkg::t_out_beat o_out_beat
);
    import sos_pkg::*;

    typedef enum logic [1:0] {SLOT_LEAD, SLOT_CHAR, SLOT_TRAIL} t_slot;

    t_slot     r_slot, n_slot;
    t_slot     slot;
    t_out_beat r_out, n_out;
    logic      r_out_valid;
    logic      lead, trail;
    logic      job_last;
    logic      out_taken;
    logic      load;

    always_comb begin
        lead  = 1'b0;
        trail = 1'b0;
        if (i_job.first) begin
            trail = (i_job.ch == CH_SEMI) && (i_job.nxt != CH_SPACE) &&
                    (i_job.nxt != CH_SEMI);
        end else if (i_job.ch == CH_SEMI) begin
            if (i_job.nxt == CH_SEMI && i_job.prev != CH_SPACE && i_job.prev != CH_SEMI) begin
                lead = 1'b1;
            end else if (i_job.prev == CH_SEMI && i_job.nxt != CH_SPACE) begin
                trail = 1'b1;
            end else begin
                lead  = (i_job.prev != CH_SPACE);
                trail = (i_job.nxt != CH_SPACE);
            end
        end else if (i_job.ch == CH_AMP || i_job.ch == CH_BAR) begin
            if (i_job.nxt == i_job.ch && i_job.prev != CH_SPACE) begin
                lead = 1'b1;
            end else if (i_job.prev == i_job.ch && i_job.nxt != CH_SPACE) begin
                trail = 1'b1;
            end
        end

        // skip an unused leading space
        slot = (r_slot == SLOT_LEAD && !lead) ? SLOT_CHAR : r_slot;

        job_last = i_job.bare || (slot == SLOT_TRAIL) || (slot == SLOT_CHAR && !trail);

        if (i_job.bare) begin
            n_out.out_byte   = CH_NUL;
            n_out.byte_valid = 1'b0;
        end else begin
            n_out.out_byte   = (slot == SLOT_CHAR) ? i_job.ch : CH_SPACE;
            n_out.byte_valid = 1'b1;
        end
        n_out.line_done = i_job.done && job_last;

        unique case (slot)
            SLOT_LEAD:  n_slot = SLOT_CHAR;
            SLOT_CHAR:  n_slot = SLOT_TRAIL;
            default:    n_slot = SLOT_LEAD;
        endcase
        if (job_last) begin
            n_slot = SLOT_LEAD;
        end
    end

    assign out_taken  = i_pop && r_out_valid;
    assign load       = i_job_valid && (!r_out_valid || out_taken);
    assign o_job_pop  = load && job_last;
    assign o_empty    = !r_out_valid;
    assign o_out_beat = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_slot      <= SLOT_LEAD;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_slot      <= n_slot;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sv/sos_checker.sv -----
// Port-level checks of the shell operator spacer, bound to the top level.
// Depends on sos_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sos_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input sos_pkg::t_out_beat o_out_beat
);
    import sos_pkg::*;

    // a bare marker always closes a line and carries no byte
    `SOS_ASSERT(a_bare_ends_line, i_clk, i_rst_n, !empty && !o_out_beat.byte_valid |-> o_out_beat.line_done && (o_out_beat.out_byte == CH_NUL), "bare result without line end")

    // reset leaves both sides drained
    `SOS_ASSERT_NORST(a_reset_drains, i_clk, !i_rst_n |=> empty && !full, "block not idle after reset")

    // hold a stalled result beat
    `SOS_ASSERT(a_out_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_out_beat), "stalled result changed")

endmodule

bind shell_operator_spacer sos_checker u_sos_checker (.*);
